// ----- src/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// Holds the request codes, the widths and the command struct used between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic lookup;    // register key match and victim choice
    logic update;    // apply the table change and form the result
  } lfu_cmd_t;

endpackage

// ----- src/lfu_if.sv -----
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if: valid/ready channels of the LFU cache table
// Request carries the operation, key and value; response carries the result.
// ----------------------------------------------------------------------------
interface lfu_req_if;
  logic req_type;
  logic signed [31:0] key;
  logic signed [31:0] value;
  logic valid;
  logic ready;
  modport source (output valid, req_type, key, value, input ready);
  modport sink (input valid, req_type, key, value, output ready);
endinterface

interface lfu_rsp_if;
  logic hit;
  logic signed [31:0] read_value;
  logic evicted;
  logic signed [31:0] evicted_key;
  logic valid;
  logic ready;
  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ----- src/lfu_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfu_ctrl: request sequencer of the LFU cache table
// Steps each request through capture, lookup and update, then holds the
// result until it is taken.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output lfu_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_UPD, S_OUT} state_t;
  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.lookup  = (state == S_LOOK);
    cmd.update  = (state == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_LOOK;
        S_LOOK: state <= S_UPD;
        S_UPD:  state <= S_OUT;
        S_OUT:  if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/lfu_dp.sv -----
// ----------------------------------------------------------------------------
// lfu_dp: entry table and replacement datapath of the LFU cache table
// Parallel key match, registered victim choice, then count/rank update.
// ----------------------------------------------------------------------------
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lfu_cmd_t                cmd,
  input  logic [CAP_W-1:0]        capacity,
  input  logic                    req_type,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [VAL_W-1:0] value,
  output logic                    hit,
  output logic signed [VAL_W-1:0] read_value,
  output logic                    evicted,
  output logic signed [KEY_W-1:0] evicted_key
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW = $clog2(MAX_ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [MAX_ENTRIES-1:0] vld;
  logic [KEY_W-1:0]       ekey [MAX_ENTRIES];
  logic [VAL_W-1:0]       eval [MAX_ENTRIES];
  logic [COUNT_BITS-1:0]  ecnt [MAX_ENTRIES];
  logic [IW-1:0]          erank[MAX_ENTRIES];

  logic            r_put;
  logic [KEY_W-1:0] r_key;
  logic [VAL_W-1:0] r_val;

  // lookup results, registered
  logic          m_hit, m_full, m_vic_ok;
  logic [IW-1:0] m_idx, m_vic;

  // combinational search
  logic          c_hit, c_vic_ok, c_free_ok;
  logic [IW-1:0] c_idx, c_vic, c_free;
  logic [NW-1:0] c_occ;
  logic [NW-1:0] cap_sat;

  // victim tree nodes
  logic                  v_ok  [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] v_cnt [MAX_ENTRIES];
  logic [IW-1:0]         v_rank[MAX_ENTRIES];
  logic [IW-1:0]         v_idx [MAX_ENTRIES];

  always_comb begin
    cap_sat = (32'(capacity) > MAX_ENTRIES) ? NW'(MAX_ENTRIES) : NW'(capacity);
  end

  always_comb begin
    c_hit = 1'b0; c_idx = '0; c_occ = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (vld[i]) begin
        c_occ = c_occ + NW'(1);
        if (!c_hit && ekey[i] == r_key) begin
          c_hit = 1'b1; c_idx = IW'(i);
        end
      end
    end
  end

  // pairwise reduction: lowest count wins, oldest rank breaks a tie
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      v_ok[i]   = vld[i];
      v_cnt[i]  = ecnt[i];
      v_rank[i] = erank[i];
      v_idx[i]  = IW'(i);
    end
    for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
      for (int i = 0; i + s < MAX_ENTRIES; i = i + 2 * s) begin
        if (v_ok[i+s] && (!v_ok[i] || v_cnt[i+s] < v_cnt[i] ||
            (v_cnt[i+s] == v_cnt[i] && v_rank[i+s] > v_rank[i]))) begin
          v_ok[i]   = 1'b1;
          v_cnt[i]  = v_cnt[i+s];
          v_rank[i] = v_rank[i+s];
          v_idx[i]  = v_idx[i+s];
        end
      end
    end
    c_vic_ok = v_ok[0];
    c_vic    = v_idx[0];
  end

  // first free slot after a possible eviction
  always_comb begin
    c_free_ok = 1'b0; c_free = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!vld[i] || (m_vic_ok && m_full && m_vic == IW'(i))) begin
        c_free_ok = 1'b1; c_free = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_put <= req_type; r_key <= key; r_val <= value;
    end
    if (cmd.lookup) begin
      m_hit    <= c_hit;
      m_idx    <= c_idx;
      m_vic    <= c_vic;
      m_vic_ok <= c_vic_ok;
      m_full   <= (c_occ >= cap_sat);
    end
  end

  logic          do_ins, do_ev;
  logic [IW-1:0] t_rank, ev_rank;
  assign do_ev   = r_put && cap_sat != '0 && !m_hit && m_full && m_vic_ok;
  assign do_ins  = r_put && cap_sat != '0 && !m_hit && c_free_ok;
  assign t_rank  = erank[m_idx];
  assign ev_rank = erank[m_vic];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.update) begin
      hit         <= m_hit;
      evicted     <= do_ev;
      evicted_key <= do_ev ? ekey[m_vic] : '0;
      read_value  <= r_put ? '0 : (m_hit ? eval[m_idx] : '1);
      if (m_hit && (!r_put || cap_sat != '0)) begin
        if (r_put) eval[m_idx] <= r_val;
        if (ecnt[m_idx] != CMAX) ecnt[m_idx] <= ecnt[m_idx] + 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (vld[i] && IW'(i) != m_idx && erank[i] < t_rank)
            erank[i] <= erank[i] + 1'b1;
        erank[m_idx] <= '0;
      end else if (r_put && cap_sat != '0 && !m_hit) begin
        // evicted entries above its rank close the gap; insert ages all
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (vld[i] && !(do_ev && IW'(i) == m_vic)) begin
            if (do_ev && erank[i] > ev_rank) begin
              if (!do_ins) erank[i] <= erank[i] - 1'b1;
            end else if (do_ins) begin
              erank[i] <= erank[i] + 1'b1;
            end
          end
        end
        // victim slot reused by the insert stays valid
        if (do_ev && !(do_ins && c_free == m_vic)) vld[m_vic] <= 1'b0;
        if (do_ins) begin
          vld[c_free]   <= 1'b1;
          ekey[c_free]  <= r_key;
          eval[c_free]  <= r_val;
          ecnt[c_free]  <= COUNT_BITS'(1);
          erank[c_free] <= '0;
        end
      end
    end
  end

endmodule

// ----- src/lfu_cache_table_top.sv -----
// ----------------------------------------------------------------------------
// lfu_cache_table_top: LFU key-value cache with LRU tie break
// Fixed table of entries, capacity register, one result per request.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | req_type, key, value
//  rsp     | out | hit, read_value, evicted, evicted_key
//  cfg     | in  | cfg_we, cfg_data (capacity)
//
// Each request steps through capture, parallel key match and victim choice
// (registered), table update, and the result held until transfer.
// The next request is taken after the response transfer; a stalled response
// holds the block. rst clears the valid bits and sets capacity to 16.
module lfu_cache_table_top
  import lfu_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  lfu_req_if.sink          req,
  lfu_rsp_if.source        rsp
);

  logic [CAP_W-1:0] capacity;
  lfu_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_W'(16);
    else if (cfg_we) capacity <= cfg_data;
  end

  lfu_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd
  );

  lfu_dp #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cmd, .capacity,
    .req_type(req.req_type), .key(req.key), .value(req.value),
    .hit(rsp.hit), .read_value(rsp.read_value),
    .evicted(rsp.evicted), .evicted_key(rsp.evicted_key)
  );

endmodule

// ----- tb/sv/lfu_tb_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_scoreboard: table model and response checker for the LFU cache
// Mirrors the cache table, works out the response of each accepted request
// and compares responses against the oldest pending expectation.
// ----------------------------------------------------------------------------
class lfu_cache_scoreboard;
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } lfu_rsp_t;

  localparam int N_ENT     = 16;
  localparam int COUNT_TOP = 16'hFFFF;

  bit          ent_valid [N_ENT];
  logic [31:0] ent_key   [N_ENT];
  logic [31:0] ent_val   [N_ENT];
  int unsigned ent_count [N_ENT];
  int unsigned ent_rank  [N_ENT];
  int unsigned cap_reg;
  lfu_rsp_t    pending_rsp[$];
  int          n_errors;
  int          n_hits;
  int          n_evicts;
  int          n_checked;

  function new();
    foreach (ent_valid[i]) ent_valid[i] = 0;
    cap_reg = 16;
  endfunction

  function void set_capacity(int unsigned c);
    cap_reg = c & 5'h1f;
  endfunction

  function int find_key(logic [31:0] k);
    foreach (ent_valid[i]) if (ent_valid[i] && ent_key[i] == k) return i;
    return -1;
  endfunction

  // most recent gets rank 0; newer entries age by one
  function void make_recent(int e);
    int unsigned r;
    r = ent_rank[e];
    foreach (ent_valid[i]) if (ent_valid[i] && i != e && ent_rank[i] < r) ent_rank[i]++;
    ent_rank[e] = 0;
    if (ent_count[e] < COUNT_TOP) ent_count[e]++;
  endfunction

  function void note_request(logic op, logic [31:0] k, logic [31:0] v);
    lfu_rsp_t    r;
    int          e, vic, slot, occ;
    int unsigned cap, rr;
    cap = (cap_reg > N_ENT) ? N_ENT : cap_reg;
    e = find_key(k);
    r = '0;
    r.hit = (e >= 0);
    if (op == lfu_pkg::REQ_GET) begin
      if (e >= 0) begin
        make_recent(e);
        r.read_value = ent_val[e];
      end else begin
        r.read_value = -1;
      end
    end else if (cap != 0) begin
      if (e >= 0) begin
        ent_val[e] = v;
        make_recent(e);
      end else begin
        occ = 0;
        foreach (ent_valid[i]) if (ent_valid[i]) occ++;
        if (occ >= cap) begin
          vic = -1;
          foreach (ent_valid[i]) begin
            if (ent_valid[i] && (vic < 0 || ent_count[i] < ent_count[vic] ||
                (ent_count[i] == ent_count[vic] && ent_rank[i] > ent_rank[vic])))
              vic = i;
          end
          if (vic >= 0) begin
            r.evicted = 1;
            r.evicted_key = ent_key[vic];
            ent_valid[vic] = 0;
            rr = ent_rank[vic];
            foreach (ent_valid[i]) if (ent_valid[i] && ent_rank[i] > rr) ent_rank[i]--;
            n_evicts++;
          end
        end
        slot = -1;
        foreach (ent_valid[i]) if (!ent_valid[i] && slot < 0) slot = i;
        if (slot >= 0) begin
          foreach (ent_valid[i]) if (ent_valid[i]) ent_rank[i]++;
          ent_valid[slot] = 1;
          ent_key[slot]   = k;
          ent_val[slot]   = v;
          ent_count[slot] = 1;
          ent_rank[slot]  = 0;
        end
      end
    end
    if (r.hit) n_hits++;
    pending_rsp.insert(pending_rsp.size(), r);
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  task automatic check_response(lfu_rsp_t got);
    lfu_rsp_t exp;
    if (pending_rsp.size() == 0) begin
      report("response with no request pending");
      return;
    end
    exp = pending_rsp[0];
    pending_rsp.delete(0);
    n_checked++;
    if (got.hit !== exp.hit)
      report($sformatf("hit got %0b exp %0b", got.hit, exp.hit));
    if (got.read_value !== exp.read_value)
      report($sformatf("read_value got %0d exp %0d", got.read_value, exp.read_value));
    if (got.evicted !== exp.evicted)
      report($sformatf("evicted got %0b exp %0b", got.evicted, exp.evicted));
    if (got.evicted_key !== exp.evicted_key)
      report($sformatf("evicted_key got %0d exp %0d", got.evicted_key, exp.evicted_key));
  endtask
endclass

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the LFU cache table
// Drives get/put requests over the request channel, changes the capacity
// between phases while idle, and checks every response against a table model
// kept in a scoreboard. Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module tb;
  import lfu_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  lfu_req_if req_ch();
  lfu_rsp_if rsp_ch();

  lfu_cache_table_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source)
  );

  lfu_cache_scoreboard cache_sb;

  // idle percentages for the sender and the receiver, per phase
  int send_idle_pct;
  int recv_idle_pct;
  int n_sent;

  // small key pool so hits and evictions are common
  logic [31:0] key_pool[24];

  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver: random back pressure; responses checked at the transfer edge
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        cache_sb.check_response({rsp_ch.hit, rsp_ch.read_value, rsp_ch.evicted,
                                 rsp_ch.evicted_key});
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one request transfer; random gaps before it per the current phase
  task automatic send_req(logic op, logic [31:0] k, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key      <= k;
    req_ch.value    <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    cache_sb.note_request(op, k, v);
    n_sent++;
  endtask

  // wait until every expected response has come, with the request channel idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (cache_sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // capacity changes only with the block idle
  task automatic write_capacity(int unsigned c);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= c[CAP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_sb.set_capacity(c);
  endtask

  task automatic random_burst(int n, int pool_n);
    logic        op;
    logic [31:0] k;
    repeat (n) begin
      op = 1'($urandom_range(1));
      // mostly pool keys; now and then a fully random one
      if ($urandom_range(9) == 0) k = $urandom();
      else k = key_pool[$urandom_range(pool_n - 1)];
      send_req(op, k, $urandom());
    end
  endtask

  initial begin
    int caps[7];
    cache_sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_GET;
    req_ch.key = '0;
    req_ch.value = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    n_sent = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h0000_0000;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: miss on empty table, extreme keys/values, update, hit
    send_req(REQ_GET, 32'h8000_0000, 32'h0);
    send_req(REQ_PUT, 32'h8000_0000, 32'h7fff_ffff);
    send_req(REQ_PUT, 32'h7fff_ffff, 32'h8000_0000);
    send_req(REQ_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_req(REQ_PUT, 32'h0000_0000, 32'h0000_0000);
    send_req(REQ_GET, 32'h7fff_ffff, 32'h5555_5555);
    send_req(REQ_PUT, 32'h8000_0000, 32'haaaa_aaaa);
    send_req(REQ_GET, 32'h8000_0000, 32'h0);
    // small capacity: LRU tie breaks among count-1 entries, then an LFU eviction
    write_capacity(2);
    send_req(REQ_PUT, 32'h1234_5678, 32'h1);
    send_req(REQ_PUT, 32'h0bad_cafe, 32'h2);
    send_req(REQ_PUT, 32'h0bad_cafe, 32'h3);
    send_req(REQ_PUT, 32'h0000_0011, 32'h4);
    // capacity zero: puts do nothing, gets on stored keys still hit
    write_capacity(0);
    send_req(REQ_PUT, 32'h0000_0022, 32'h5);
    send_req(REQ_PUT, 32'h8000_0000, 32'h6);
    send_req(REQ_GET, 32'h8000_0000, 32'h0);
    send_req(REQ_GET, 32'h0000_0022, 32'h0);
    // capacity above table size saturates
    write_capacity(31);
    send_req(REQ_PUT, 32'h0000_0033, 32'h7);

    // repeated hits on one key raise its count well above the others
    write_capacity(16);
    repeat (20) send_req(REQ_GET, 32'h0000_0033, 32'h0);
    send_req(REQ_PUT, 32'h0000_0044, 32'h8);

    // random phases across capacity settings and idle mixes
    caps = '{16, 1, 4, 0, 8, 20, 3};
    for (int ph = 0; ph < 7; ph++) begin
      write_capacity(caps[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 61; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 61; end
        default: begin send_idle_pct = 22; recv_idle_pct = 22; end
      endcase
      random_burst(60, 24);
      // sender holds off until all responses are in
      drain();
      random_burst(55, 12);
    end
    // capacity lowered below occupancy
    send_idle_pct = 22;
    recv_idle_pct = 22;
    write_capacity(16);
    random_burst(60, 24);
    write_capacity(5);
    random_burst(40, 24);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d requests (%0d responses checked, %0d hits, %0d evictions)",
             n_sent, cache_sb.n_checked, cache_sb.n_hits, cache_sb.n_evicts);
    $display("capacities 0, 1..16 and above 16, repeated hits, and idle/stall phases");
    if (cache_sb.n_errors == 0 && cache_sb.pending_rsp.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("timeout");
    $display("tb NOT OK");
    $finish;
  end
endmodule

// ----- sim.f -----
src/lfu_pkg.sv
src/lfu_if.sv
src/lfu_ctrl.sv
src/lfu_dp.sv
src/lfu_cache_table_top.sv
tb/sv/lfu_tb_scoreboard.sv
tb/sv/tb.sv
